### rtl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned CAP_W         = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;          // latch input beat
    logic ins_start;     // open hole at tail, count++
    logic ext_start;     // take root, count--, read tail
    logic refuse_full;
    logic refuse_empty;
    logic rd_parent;
    logic rd_children;
    logic latch_last;    // carried value <= tail read
    logic up_move;       // parent moves down into hole
    logic dn_move;       // larger child moves up into hole
    logic wr_val;        // carried value lands in hole
    logic res_load;      // result into output register
  } mhpq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_ext;
    logic full;
    logic empty;
    logic pos_zero;
    logic up_greater;
    logic dn_move;
    logic out_free;
  } mhpq_stat_t;

endpackage

### rtl/mhpq_if.sv
// Channel interfaces: input beat, result beat and configuration write.
interface mhpq_in_if;
  import mhpq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [DATA_W-1:0] value;
  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface mhpq_out_if #(
  parameter int unsigned CNT_W = 5
);
  import mhpq_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] extracted;
  logic signed [DATA_W-1:0] top_value;
  logic [CNT_W-1:0]         count;
  modport source (output valid, output status, output extracted, output top_value,
                  output count, input ready);
  modport sink   (input valid, input status, input extracted, input top_value,
                  input count, output ready);
endinterface

interface mhpq_cfg_if;
  import mhpq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/mhpq_datapath.sv
// Heap datapath: element store, hole position, carried value, count and result register.
module mhpq_datapath import mhpq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  mhpq_cmd_t                cmd_i,
  output mhpq_stat_t               stat_o,
  input  logic                     in_mode_i,
  input  logic signed [DATA_W-1:0] in_value_i,
  input  logic                     cfg_we_i,
  input  logic [CAP_W-1:0]         cfg_data_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [1:0]               out_status_o,
  output logic signed [DATA_W-1:0] out_extracted_o,
  output logic signed [DATA_W-1:0] out_top_value_o,
  output logic [CNT_W-1:0]         out_count_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned IW = AW + 2;
  localparam int unsigned LW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic signed [DATA_W-1:0] rd_a_q, rd_b_q;
  logic signed [DATA_W-1:0] val_q, root_q, ext_q;
  logic                     op_q;
  logic [AW-1:0]            pos_q, pos_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [CAP_W-1:0]         cap_q;
  logic [1:0]               res_st_q;
  logic                     out_valid_q;
  logic [1:0]               out_status_q;
  logic signed [DATA_W-1:0] out_ext_q, out_top_q;
  logic [CNT_W-1:0]         out_count_q;

  logic [AW-1:0]            parent;
  logic [IW-1:0]            l_idx, r_idx, n_ext;
  logic                     l_ok, r_ok;
  logic [CNT_W-1:0]         last;
  logic [AW-1:0]            rd_a_addr, rd_b_addr;
  logic                     take_l, take_r;
  logic signed [DATA_W-1:0] best_val, child_val, wr_data;
  logic [IW-1:0]            child_idx;
  logic                     wr_en;

  assign parent    = (pos_q - AW'(1)) >> 1;
  assign l_idx     = {1'b0, pos_q, 1'b1};
  assign r_idx     = l_idx + IW'(1);
  assign n_ext     = IW'(count_q);
  assign l_ok      = l_idx < n_ext;
  assign r_ok      = r_idx < n_ext;
  assign last      = count_q - CNT_W'(1);

  always_comb begin
    if (cmd_i.ext_start) begin
      rd_a_addr = last[AW-1:0];
    end else if (cmd_i.rd_children) begin
      rd_a_addr = l_ok ? l_idx[AW-1:0] : '0;
    end else begin
      rd_a_addr = parent;
    end
  end
  assign rd_b_addr = r_ok ? r_idx[AW-1:0] : '0;

  // sift-down pick: left wins ties with right, child must beat carried value strictly
  assign take_l    = l_ok && (rd_a_q > val_q);
  assign best_val  = take_l ? rd_a_q : val_q;
  assign take_r    = r_ok && (rd_b_q > best_val);
  assign child_val = take_r ? rd_b_q : rd_a_q;
  assign child_idx = take_r ? r_idx : l_idx;

  assign wr_en = cmd_i.wr_val | cmd_i.up_move | cmd_i.dn_move;
  always_comb begin
    priority if (cmd_i.up_move) begin
      wr_data = rd_a_q;
    end else if (cmd_i.dn_move) begin
      wr_data = child_val;
    end else begin
      wr_data = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[pos_q] <= wr_data;
    end
    rd_a_q <= mem[rd_a_addr];
    rd_b_q <= mem[rd_b_addr];
  end

  always_comb begin
    pos_d = pos_q;
    priority if (cmd_i.ins_start) begin
      pos_d = count_q[AW-1:0];
    end else if (cmd_i.ext_start) begin
      pos_d = '0;
    end else if (cmd_i.up_move) begin
      pos_d = parent;
    end else if (cmd_i.dn_move) begin
      pos_d = child_idx[AW-1:0];
    end
  end

  always_comb begin
    count_d = count_q;
    priority if (cmd_i.ins_start) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.ext_start) begin
      count_d = last;
    end
  end

  // payload-side registers
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    if (cmd_i.load) begin
      op_q  <= in_mode_i;
      val_q <= in_value_i;
    end else if (cmd_i.latch_last) begin
      val_q <= rd_a_q;
    end
    if (wr_en && (pos_q == '0)) begin
      root_q <= wr_data;
    end
    priority if (cmd_i.ext_start) begin
      ext_q    <= root_q;
      res_st_q <= ST_OK;
    end else if (cmd_i.ins_start) begin
      ext_q    <= '0;
      res_st_q <= ST_OK;
    end else if (cmd_i.refuse_full) begin
      ext_q    <= '0;
      res_st_q <= ST_FULL;
    end else if (cmd_i.refuse_empty) begin
      ext_q    <= '1;
      res_st_q <= ST_EMPTY;
    end
    if (cmd_i.res_load) begin
      out_status_q <= res_st_q;
      out_ext_q    <= ext_q;
      out_top_q    <= (count_q != '0) ? root_q : '0;
      out_count_q  <= count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (cmd_i.res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.is_ext     = (op_q == MODE_EXTRACT);
  assign stat_o.full       = (LW'(count_q) >= LW'(cap_q)) || (count_q == CNT_W'(DEPTH));
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.pos_zero   = (pos_q == '0);
  assign stat_o.up_greater = val_q > rd_a_q;
  assign stat_o.dn_move    = take_l | take_r;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_extracted_o = out_ext_q;
  assign out_top_value_o = out_top_q;
  assign out_count_o     = out_count_q;

endmodule

### rtl/mhpq_ctrl.sv
// Heap controller: sequences insert sift-up and extract sift-down over the datapath.
module mhpq_ctrl import mhpq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  mhpq_stat_t stat_i,
  output mhpq_cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_START   = 3'd1;
  localparam logic [2:0] S_UP_RD   = 3'd2;
  localparam logic [2:0] S_UP_CMP  = 3'd3;
  localparam logic [2:0] S_DN_LAST = 3'd4;
  localparam logic [2:0] S_DN_RD   = 3'd5;
  localparam logic [2:0] S_DN_CMP  = 3'd6;
  localparam logic [2:0] S_DONE    = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_START;
        end
      end
      S_START: begin
        if (!stat_i.is_ext) begin
          if (stat_i.full) begin
            cmd_o.refuse_full = 1'b1;
            state_d           = S_DONE;
          end else begin
            cmd_o.ins_start = 1'b1;
            state_d         = S_UP_RD;
          end
        end else if (stat_i.empty) begin
          cmd_o.refuse_empty = 1'b1;
          state_d            = S_DONE;
        end else begin
          cmd_o.ext_start = 1'b1;
          state_d         = S_DN_LAST;
        end
      end
      S_UP_RD: begin
        if (stat_i.pos_zero) begin
          cmd_o.wr_val = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.rd_parent = 1'b1;
          state_d         = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_greater) begin
          cmd_o.up_move = 1'b1;
          state_d       = S_UP_RD;
        end else begin
          cmd_o.wr_val = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DN_LAST: begin
        cmd_o.latch_last = 1'b1;
        state_d          = S_DN_RD;
      end
      S_DN_RD: begin
        cmd_o.rd_children = 1'b1;
        state_d           = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (stat_i.dn_move) begin
          cmd_o.dn_move = 1'b1;
          state_d       = S_DN_RD;
        end else begin
          cmd_o.wr_val = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/max_heap_priority_queue_core.sv
// Top level of the max-heap priority queue: controller, datapath and channel hookup.
//
// Usage notes:
// - in_i carries one operation per beat: mode 0 inserts value, mode 1 extracts the max.
// - out_o returns exactly one beat per operation: status, extracted value, current
//   maximum (top_value, 0 when empty) and element count after the operation.
// - cfg_i writes capacity_limit; always ready. Write only while the queue is idle.
// - One operation at a time. in_i.ready is high only while the controller is idle.
// - An insert opens a hole at the tail and moves it up level by level; an extract
//   takes the root, latches the tail value and moves the hole down level by level;
//   refused ops go straight to the result. With DEPTH = 16 the worst case is an
//   insert rising four levels or an extract sinking three. Each level is one
//   registered read of the store, then compare and a single write.
// - The next beat is taken the cycle after the result loads; operations never overlap.
// - The result sits in an output register, so a new beat is taken while it waits;
//   a stalled receiver only holds the controller once the next result is ready.
// - Reset empties the heap (count 0), sets capacity_limit to 16 and drops any
//   pending result. Store contents are not cleared and never read before written.
module max_heap_priority_queue_core import mhpq_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEFAULT,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mhpq_in_if.sink          in_i,
  mhpq_out_if.source       out_o,
  mhpq_cfg_if.sink         cfg_i
);

  mhpq_cmd_t  cmd;
  mhpq_stat_t stat;
  logic       in_ready;

  // controller owns the input handshake
  mhpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // store, counters, config register and result register
  mhpq_datapath #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_mode_i       (in_i.mode),
    .in_value_i      (in_i.value),
    .cfg_we_i        (cfg_i.valid),
    .cfg_data_i      (cfg_i.data),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .out_status_o    (out_o.status),
    .out_extracted_o (out_o.extracted),
    .out_top_value_o (out_o.top_value),
    .out_count_o     (out_o.count)
  );

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;  // every write goes straight into the capacity register

endmodule

### rtl/mhpq_checker.sv
// Port-level checker for the max-heap priority queue, bound to the top level.
module mhpq_checker import mhpq_pkg::*; #(
  parameter int unsigned CNT_W = 5
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic [1:0]               out_status_i,
  input logic signed [DATA_W-1:0] out_extracted_i,
  input logic signed [DATA_W-1:0] out_top_value_i,
  input logic [CNT_W-1:0]         out_count_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
      $stable(out_extracted_i) && $stable(out_top_value_i) && $stable(out_count_i))
    else $error("result beat changed while stalled");

  a_empty_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_EMPTY) |->
      (out_count_i == '0) && (out_extracted_i == -32'sd1))
    else $error("empty extract result malformed");

  a_full_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_FULL) |-> (out_extracted_i == '0))
    else $error("refused insert reports nonzero extracted");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_count_i == '0) |-> (out_top_value_i == '0))
    else $error("top_value nonzero on empty heap");

endmodule

bind max_heap_priority_queue_core mhpq_checker #(
  .CNT_W (CNT_W)
) u_mhpq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_status_i    (out_o.status),
  .out_extracted_i (out_o.extracted),
  .out_top_value_i (out_o.top_value),
  .out_count_i     (out_o.count)
);

### verif/testbench.sv
// Self-checking testbench for the max-heap priority queue core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mhpq_pkg::*;

  localparam int unsigned HEAP_DEPTH = DEPTH_DEFAULT;
  // cycles with no beat on any channel before the run is declared hung
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // settle at the end for a bit longer than the worst-case op latency
  localparam int unsigned END_SETTLE = 30;

  // one expected result beat
  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] extracted;
    logic signed [DATA_W-1:0] top_value;
    logic [CAP_W-1:0]         count;
  } heap_result_t;

  // Shadow heap: mirrors the store, the element count and capacity_limit,
  // and queues the result each accepted operation should produce.
  class heap_scoreboard;
    logic signed [DATA_W-1:0] heap_mem [HEAP_DEPTH];
    int unsigned              elem_count;
    logic [CAP_W-1:0]         cap_limit;
    heap_result_t             pending_results [$];
    int unsigned              errors;
    int unsigned              n_insert, n_extract, n_full, n_empty, peak_count;

    function new();
      elem_count = 0;
      cap_limit  = CAP_RESET;
      errors     = 0;
      n_insert   = 0;
      n_extract  = 0;
      n_full     = 0;
      n_empty    = 0;
      peak_count = 0;
    endfunction

    function void set_limit(logic [CAP_W-1:0] v);
      cap_limit = v;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic signed [DATA_W-1:0] t;
      t           = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = t;
    endfunction

    // apply one operation to the shadow heap and queue its result
    function void apply_heap_op(logic mode, logic signed [DATA_W-1:0] value);
      heap_result_t r;
      int unsigned  eff_limit, pos, parent, best, lc, rc;
      bit           settled;
      eff_limit   = (cap_limit < HEAP_DEPTH) ? cap_limit : HEAP_DEPTH;
      r.status    = ST_OK;
      r.extracted = '0;
      if (mode == MODE_INSERT) begin
        n_insert++;
        if (elem_count >= eff_limit) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          pos           = elem_count;
          heap_mem[pos] = value;
          elem_count++;
          settled = 0;
          while (pos > 0 && !settled) begin
            parent = (pos - 1) / 2;
            if (heap_mem[pos] > heap_mem[parent]) begin
              swap_slots(pos, parent);
              pos = parent;
            end else begin
              settled = 1;
            end
          end
        end
      end else begin
        n_extract++;
        if (elem_count == 0) begin
          r.status    = ST_EMPTY;
          r.extracted = -1;
          n_empty++;
        end else begin
          r.extracted = heap_mem[0];
          heap_mem[0] = heap_mem[elem_count-1];
          elem_count--;
          pos     = 0;
          settled = 0;
          while (!settled) begin
            best = pos;
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            // strict compares: on a tie the left child wins
            if (lc < elem_count && heap_mem[lc] > heap_mem[best]) best = lc;
            if (rc < elem_count && heap_mem[rc] > heap_mem[best]) best = rc;
            if (best == pos) begin
              settled = 1;
            end else begin
              swap_slots(pos, best);
              pos = best;
            end
          end
        end
      end
      if (elem_count > peak_count) peak_count = elem_count;
      r.top_value = (elem_count != 0) ? heap_mem[0] : '0;
      r.count     = elem_count[CAP_W-1:0];
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] ext,
                               logic signed [DATA_W-1:0] top, logic [CAP_W-1:0] cnt);
      heap_result_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected (status %0d count %0d)",
                 $time, st, cnt);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (st !== e.status) begin
          $display("%0t: status exp %0d act %0d", $time, e.status, st);
          errors++;
        end
        if (ext !== e.extracted) begin
          $display("%0t: extracted exp %0d act %0d", $time, e.extracted, ext);
          errors++;
        end
        if (top !== e.top_value) begin
          $display("%0t: top_value exp %0d act %0d", $time, e.top_value, top);
          errors++;
        end
        if (cnt !== e.count) begin
          $display("%0t: count exp %0d act %0d", $time, e.count, cnt);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  always #5 clk_i = ~clk_i;

  mhpq_in_if                 in_ch ();
  mhpq_out_if #(.CNT_W(CAP_W)) out_ch ();
  mhpq_cfg_if                cfg_ch ();

  max_heap_priority_queue_core #(.DEPTH(HEAP_DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  heap_scoreboard sb = new();

  // traffic shaping knobs, set per phase by the main sequence
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off_len = 0;
  int unsigned n_settings = 0;

  // Monitor: every accepted beat on every channel goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) sb.set_limit(cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sb.apply_heap_op(in_ch.mode, in_ch.value);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.status, out_ch.extracted, out_ch.top_value, out_ch.count);
    end
  end

  // Result receiver. A requested hold-off keeps ready low for a long,
  // self-counted stretch; otherwise ready stalls at the phase's rate.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_len != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready) || !rst_ni)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no channel activity for %0d cycles", $time, STALL_LIMIT);
    $display("testbench: errors");
    $finish;
  end

  // Offer one operation. Valid is left high after the beat; the next call
  // either keeps it up with new data or drops it for an idle gap.
  task automatic send_op(logic mode, logic signed [DATA_W-1:0] value);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= mode;
    in_ch.value <= value;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every expected result has been taken.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_results.size() != 0);
  endtask

  // capacity_limit write; only called with the queue drained
  task automatic write_limit(logic [CAP_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    n_settings++;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom_range(7) - 4;      // narrow range, lots of ties
      1: begin
        case ($urandom_range(3))
          0: v = 32'sh7fff_ffff;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Random phase: alternating fill and drain stretches so the heap
  // regularly reaches both the limit and empty.
  task automatic run_phase(logic [CAP_W-1:0] cap, int unsigned idle_pct,
                           int unsigned stall_pct, int unsigned n_ops, bit hold);
    int unsigned ins_pct;
    write_limit(cap);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    if (hold) hold_off_len = HOLD_OFF_CYCLES;
    for (int unsigned i = 0; i < n_ops; i++) begin
      ins_pct = ((i / 20) % 2 == 0) ? 80 : 25;
      send_op(($urandom_range(99) < ins_pct) ? MODE_INSERT : MODE_EXTRACT, pick_value());
    end
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode  = MODE_INSERT;
    in_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset limit of 16, no idling on either side.
    send_op(MODE_EXTRACT, 32'sh1234_5678);  // empty extract, value ignored
    send_op(MODE_INSERT, 32'sh7fff_ffff);
    send_op(MODE_INSERT, 32'sh8000_0000);
    send_op(MODE_INSERT, 32'sh0000_0000);
    send_op(MODE_INSERT, -32'sd1);
    send_op(MODE_INSERT, 32'sd5);
    send_op(MODE_INSERT, 32'sd5);
    send_op(MODE_INSERT, 32'sd5);
    repeat (7) send_op(MODE_EXTRACT, $urandom);
    send_op(MODE_EXTRACT, -32'sd1);         // empty again
    drain();
    // small limit: third insert refused, equal values do not swap
    write_limit(5'd2);
    send_op(MODE_INSERT, 32'sd9);
    send_op(MODE_INSERT, 32'sd9);
    send_op(MODE_INSERT, 32'sd1);
    drain();
    // limit dropped below the count: inserts refused, extracts still work
    write_limit(5'd1);
    send_op(MODE_INSERT, 32'sd3);
    send_op(MODE_EXTRACT, '0);
    send_op(MODE_EXTRACT, '0);
    drain();
    // zero limit: every insert refused
    write_limit(5'd0);
    send_op(MODE_INSERT, 32'sh7fff_ffff);
    send_op(MODE_EXTRACT, '0);
    drain();

    // Random phases.
    run_phase(5'd31, 0, 0, 100, 1'b0);                            // limit above depth
    run_phase(5'd16, 86, 0, 90, 1'b0);
    run_phase(5'($urandom_range(3, 15)), 0, 86, 90, 1'b0);
    run_phase(5'($urandom_range(1, 16)), 23, 23, 90, 1'b0);
    run_phase(5'd16, 0, 0, 80, 1'b1);                             // long receiver hold-off
    run_phase(5'd1, 23, 23, 40, 1'b0);

    repeat (END_SETTLE) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               sb.pending_results.size());
      sb.errors++;
    end
    $display("ran %0d inserts and %0d extracts over %0d limit settings, heap peak %0d",
             sb.n_insert, sb.n_extract, n_settings, sb.peak_count);
    $display("refused: %0d on full heap, %0d on empty heap; %0d mismatches",
             sb.n_full, sb.n_empty, sb.errors);
    if (sb.errors == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

### max_heap_priority_queue_core.f
rtl/mhpq_pkg.sv
rtl/mhpq_if.sv
rtl/mhpq_datapath.sv
rtl/mhpq_ctrl.sv
rtl/max_heap_priority_queue_core.sv
rtl/mhpq_checker.sv
verif/testbench.sv
